### sv/slfd_pkg.sv
// ----------------------------------------------------------------------------
// slfd_pkg: shared types and constants of the frame deframer router
// Byte codes, result kinds, route classes and the parser state encoding.
// ----------------------------------------------------------------------------
package slfd_pkg;

   localparam logic [7:0]  SYNC_BYTE        = 8'hEF;
   localparam logic [1:0]  SYNC_LAST        = 2'd3;
   localparam logic [2:0]  TRAILER_LEN      = 3'd4;
   localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd1014;
   localparam logic [1:0]  PULSE_FULL       = 2'd3;
   localparam logic [15:0] PULSE_LAST_IDX   = 16'd4;

   localparam logic [7:0]  CHR_0 = 8'h30;
   localparam logic [7:0]  CHR_1 = 8'h31;
   localparam logic [7:0]  CHR_2 = 8'h32;
   localparam logic [7:0]  CHR_3 = 8'h33;
   localparam logic [7:0]  CHR_4 = 8'h34;
   localparam logic [7:0]  CHR_5 = 8'h35;
   localparam logic [7:0]  CHR_6 = 8'h36;

   localparam logic [1:0]  KIND_PAYLOAD = 2'd0;
   localparam logic [1:0]  KIND_END     = 2'd1;
   localparam logic [1:0]  KIND_DROP    = 2'd2;

   localparam logic [3:0]  CLS_FORWARD    = 4'd0;
   localparam logic [3:0]  CLS_UPPER      = 4'd1;
   localparam logic [3:0]  CLS_LOWER      = 4'd5;
   localparam logic [3:0]  CLS_OFS_PULSE  = 4'd1;
   localparam logic [3:0]  CLS_OFS_STATUS = 4'd2;
   localparam logic [3:0]  CLS_OFS_MSG    = 4'd3;
   localparam logic [3:0]  CLS_UNEXPECTED = 4'd9;

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_LEN_HI  = 5'b00010,
      PH_LEN_LO  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_TRAILER = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] frame_length;
      logic [7:0]  route_path;
      logic [3:0]  frame_class;
   } result_type;

endpackage

### sv/slfd_class.sv
// ----------------------------------------------------------------------------
// slfd_class: route classifier
// Maps the path byte, type byte and pulse digit count to a route class.
// ----------------------------------------------------------------------------
module slfd_class (
   input  logic [7:0] path_byte,
   input  logic [7:0] type_byte,
   input  logic [1:0] pulse_digits,
   output logic [3:0] frame_class
);
   import slfd_pkg::*;

   logic [3:0] base;
   logic       base_ok;
   logic [3:0] sub;
   logic       sub_ok;

   always_comb begin
      base    = CLS_UPPER;
      base_ok = 1'b0;
      if (path_byte == CHR_3) begin
         base    = CLS_UPPER;
         base_ok = 1'b1;
      end else if (path_byte == CHR_5) begin
         base    = CLS_LOWER;
         base_ok = 1'b1;
      end
   end

   // type byte picks the offset within the upper or lower group
   always_comb begin
      sub    = 4'd0;
      sub_ok = 1'b1;
      if (type_byte == CHR_0) begin
         sub = 4'd0;
      end else if (type_byte == CHR_1) begin
         sub = (pulse_digits == PULSE_FULL) ? CLS_OFS_PULSE : CLS_OFS_STATUS;
      end else if (type_byte == CHR_2) begin
         sub = CLS_OFS_MSG;
      end else begin
         sub_ok = 1'b0;
      end
   end

   always_comb begin
      if (path_byte == CHR_0 || path_byte == CHR_4 || path_byte == CHR_6) begin
         frame_class = CLS_FORWARD;
      end else if (base_ok && sub_ok) begin
         frame_class = base + sub;
      end else begin
         frame_class = CLS_UNEXPECTED;
      end
   end

endmodule

### sv/slfd_parse.sv
// ----------------------------------------------------------------------------
// slfd_parse: frame parser
// Holds the parse state and works out the result of one byte per step.
// ----------------------------------------------------------------------------
module slfd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic [15:0]          max_payload,
   output slfd_pkg::result_type result
);
   import slfd_pkg::*;

   phase_type   phase_ff,        phase_in;
   logic [1:0]  sync_seen_ff,    sync_seen_in;
   logic [15:0] length_value_ff, length_value_in;
   logic [15:0] byte_count_ff,   byte_count_in;
   logic [2:0]  trailer_left_ff, trailer_left_in;
   logic [7:0]  path_byte_ff,    path_byte_in;
   logic [7:0]  type_byte_ff,    type_byte_in;
   logic [1:0]  pulse_digits_ff, pulse_digits_in;

   logic [3:0]  frame_class;
   logic [15:0] full_length;
   logic [15:0] count_next;
   logic [2:0]  trailer_next;

   slfd_class u_class (
      .path_byte    (path_byte_ff),
      .type_byte    (type_byte_ff),
      .pulse_digits (pulse_digits_ff),
      .frame_class  (frame_class)
   );

   assign full_length  = {length_value_ff[15:8], rx_byte};
   assign count_next   = byte_count_ff + 16'd1;
   assign trailer_next = (trailer_left_ff != 3'd0) ? trailer_left_ff - 3'd1 : 3'd0;

   always_comb begin
      phase_in        = phase_ff;
      sync_seen_in    = sync_seen_ff;
      length_value_in = length_value_ff;
      byte_count_in   = byte_count_ff;
      trailer_left_in = trailer_left_ff;
      path_byte_in    = path_byte_ff;
      type_byte_in    = type_byte_ff;
      pulse_digits_in = pulse_digits_ff;
      result          = '0;

      unique case (phase_ff)
         PH_LEN_HI: begin
            length_value_in = {rx_byte, 8'd0};
            phase_in        = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_value_in = full_length;
            byte_count_in   = '0;
            path_byte_in    = '0;
            type_byte_in    = '0;
            pulse_digits_in = '0;
            if (full_length > max_payload) begin
               phase_in            = PH_HUNT;
               sync_seen_in        = '0;
               result.valid        = 1'b1;
               result.kind         = KIND_DROP;
               result.frame_length = full_length;
            end else if (full_length == 16'd0) begin
               phase_in        = PH_TRAILER;
               trailer_left_in = TRAILER_LEN;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (byte_count_ff == 16'd0) begin
               path_byte_in = rx_byte;
            end else if (byte_count_ff == 16'd1) begin
               type_byte_in = rx_byte;
            end else if (byte_count_ff <= PULSE_LAST_IDX && rx_byte == CHR_6) begin
               pulse_digits_in = pulse_digits_ff + 2'd1;
            end
            byte_count_in = count_next;
            if (count_next >= length_value_ff) begin
               phase_in        = PH_TRAILER;
               trailer_left_in = TRAILER_LEN;
            end
            result.valid      = 1'b1;
            result.kind       = KIND_PAYLOAD;
            result.data_byte  = rx_byte;
            result.first_byte = (byte_count_ff == 16'd0);
         end
         PH_TRAILER: begin
            trailer_left_in = trailer_next;
            if (trailer_next == 3'd0) begin
               phase_in            = PH_HUNT;
               sync_seen_in        = '0;
               result.valid        = 1'b1;
               result.kind         = KIND_END;
               result.frame_length = length_value_ff;
               result.route_path   = path_byte_ff;
               result.frame_class  = frame_class;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == SYNC_BYTE) begin
               if (sync_seen_ff == SYNC_LAST) begin
                  sync_seen_in = '0;
                  phase_in     = PH_LEN_HI;
               end else begin
                  sync_seen_in = sync_seen_ff + 2'd1;
               end
            end else begin
               sync_seen_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         sync_seen_ff    <= '0;
         length_value_ff <= '0;
         byte_count_ff   <= '0;
         trailer_left_ff <= '0;
         path_byte_ff    <= '0;
         type_byte_ff    <= '0;
         pulse_digits_ff <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         sync_seen_ff    <= sync_seen_in;
         length_value_ff <= length_value_in;
         byte_count_ff   <= byte_count_in;
         trailer_left_ff <= trailer_left_in;
         path_byte_ff    <= path_byte_in;
         type_byte_ff    <= type_byte_in;
         pulse_digits_ff <= pulse_digits_in;
      end
   end

endmodule

### sv/sync_length_frame_deframer_router_unit.sv
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_router_unit: sync word frame deframer and router
// Hunts for the sync word, reads the length header, passes payload bytes on
// and reports each frame end with its length and route class.
// ----------------------------------------------------------------------------
// usage
//   req_*  : one received link byte per item (valid / stall)
//   rsp_*  : zero or one result item per byte: a payload byte, a frame end
//            with length and route class, or an oversize drop flag
//   csr_*  : write channel for max_payload, always ready; write it only
//            while no byte is in flight
// timing
//   a byte is taken into the input register, parsed in the next cycle and
//   its result lands in the output register: rsp_valid rises one cycle after
//   acceptance; one byte per clock sustained, set by the single parse stage
// reset
//   parser back to hunting, both registers empty, max_payload = 1014
// stall
//   a held result in the output register blocks the parse stage; the input
//   register still takes one more byte, after which req_stall rises
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_router_unit (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_first_byte,
   output logic [15:0] rsp_frame_length,
   output logic [7:0]  rsp_route_path,
   output logic [3:0]  rsp_frame_class,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import slfd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic [15:0] max_payload_ff;

   result_type  result;
   logic        out_free;
   logic        step;
   logic        req_take;

   // parse stage moves when the output register is empty or draining
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   slfd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   // input register: refilled when its byte moves on
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // output register: bytes that give no result leave it untouched
   always_comb begin
      if (step && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_first_byte   = rsp_ff.first_byte;
   assign rsp_frame_length = rsp_ff.frame_length;
   assign rsp_route_path   = rsp_ff.route_path;
   assign rsp_frame_class  = rsp_ff.frame_class;

endmodule

### test/tb_sync_length_frame_deframer_router_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_frame_deframer_router_unit: self-checking bench of the deframer
// Feeds sync-framed byte streams with random content, noise and broken
// headers, predicts every payload, frame-end and drop item in a scoreboard
// class and compares each result field by field, mostly under random stalls.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_deframer_router_unit;
   import slfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam int SETTLE_CYCLES  = 6;      // two-stage pipe plus margin
   localparam int PHASE_ITEMS    = 170;    // framed bytes per setting

   // one expected result item
   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] frame_length;
      logic [7:0]  route_path;
      logic [3:0]  frame_class;
   } deframe_result_type;

   // --------------------------------------------------------------------------
   // scoreboard: own copy of the parser state, expected results in order
   // --------------------------------------------------------------------------
   class deframe_scoreboard;
      logic [15:0]        max_len;
      phase_type          stage;
      logic [2:0]         sync_run;
      logic [15:0]        hdr_len;
      logic [15:0]        pay_count;
      logic [2:0]         trail_left;
      logic [7:0]         path_byte;
      logic [7:0]         type_byte;
      logic [2:0]         six_count;
      deframe_result_type expected_results[$];
      int                 errors;

      function new();
         max_len    = MAX_PAYLOAD_RST;
         stage      = PH_HUNT;
         sync_run   = '0;
         hdr_len    = '0;
         pay_count  = '0;
         trail_left = '0;
         path_byte  = '0;
         type_byte  = '0;
         six_count  = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function logic [3:0] route_class();
         logic [3:0] base;
         if (path_byte == CHR_0 || path_byte == CHR_4 || path_byte == CHR_6)
            return CLS_FORWARD;
         if (path_byte == CHR_3) base = CLS_UPPER;
         else if (path_byte == CHR_5) base = CLS_LOWER;
         else return CLS_UNEXPECTED;
         if (type_byte == CHR_0) return base;
         if (type_byte == CHR_1)
            return (six_count == 3'(PULSE_FULL)) ? base + CLS_OFS_PULSE
                                                 : base + CLS_OFS_STATUS;
         if (type_byte == CHR_2) return base + CLS_OFS_MSG;
         return CLS_UNEXPECTED;
      endfunction

      // one accepted byte: advance the parser, queue what it should produce
      function void note_byte(logic [7:0] b);
         deframe_result_type r;
         bit                 emit;
         r    = '{kind: KIND_PAYLOAD, data_byte: 8'h00, first_byte: 1'b0,
                  frame_length: 16'h0000, route_path: 8'h00, frame_class: CLS_FORWARD};
         emit = 1'b0;
         case (stage)
            PH_LEN_HI: begin
               hdr_len = {b, 8'h00};
               stage   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               hdr_len[7:0] = b;
               pay_count = '0;
               path_byte = '0;
               type_byte = '0;
               six_count = '0;
               if (hdr_len > max_len) begin
                  stage  = PH_HUNT;
                  sync_run = '0;
                  r.kind = KIND_DROP;
                  r.frame_length = hdr_len;
                  emit = 1'b1;
               end else if (hdr_len == 16'h0000) begin
                  stage = PH_TRAILER;
                  trail_left = TRAILER_LEN;
               end else begin
                  stage = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               r.first_byte = (pay_count == 16'h0000);
               if (pay_count == 16'h0000) path_byte = b;
               else if (pay_count == 16'h0001) type_byte = b;
               else if (pay_count <= PULSE_LAST_IDX && b == CHR_6) six_count++;
               pay_count++;
               if (pay_count >= hdr_len) begin
                  stage = PH_TRAILER;
                  trail_left = TRAILER_LEN;
               end
               r.kind = KIND_PAYLOAD;
               r.data_byte = b;
               emit = 1'b1;
            end
            PH_TRAILER: begin
               if (trail_left > 0) trail_left--;
               if (trail_left == 0) begin
                  stage = PH_HUNT;
                  sync_run = '0;
                  r.kind = KIND_END;
                  r.frame_length = hdr_len;
                  r.route_path = path_byte;
                  r.frame_class = route_class();
                  emit = 1'b1;
               end
            end
            default: begin
               stage = PH_HUNT;
               if (b == SYNC_BYTE) begin
                  sync_run++;
                  if (sync_run >= 3'd4) begin
                     sync_run = '0;
                     stage = PH_LEN_HI;
                  end
               end else begin
                  sync_run = '0;
               end
            end
         endcase
         if (emit) expected_results.push_back(r);
      endfunction

      function void cmp(string fld, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, fld, want, got);
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] data_byte,
                                 logic first_byte, logic [15:0] frame_length,
                                 logic [7:0] route_path, logic [3:0] frame_class);
         deframe_result_type w;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t mismatch result: expected none, actual kind %0d data %0d",
                     $time, kind, data_byte);
            return;
         end
         w = expected_results.pop_front();
         cmp("kind", 32'(w.kind), 32'(kind));
         cmp("data_byte", 32'(w.data_byte), 32'(data_byte));
         cmp("first_byte", 32'(w.first_byte), 32'(first_byte));
         cmp("frame_length", 32'(w.frame_length), 32'(frame_length));
         cmp("route_path", 32'(w.route_path), 32'(route_path));
         cmp("frame_class", 32'(w.frame_class), 32'(frame_class));
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // signals, the bench-driven ones set to known values from time zero
   // --------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_first_byte;
   logic [15:0] rsp_frame_length;
   logic [7:0]  rsp_route_path;
   logic [3:0]  rsp_frame_class;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   deframe_scoreboard sb = new();
   int send_gap_pct = 13;     // chance per check that the sender idles before an item
   int recv_gap_pct = 79;     // chance per cycle that the receiver stalls
   int framed_items = 0;      // bytes sent inside frames, noise not counted
   int idle_cycles  = 0;

   sync_length_frame_deframer_router_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_first_byte   (rsp_first_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_route_path   (rsp_route_path),
      .rsp_frame_class  (rsp_frame_class),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall, check every accepted result item
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_kind, rsp_data_byte, rsp_first_byte,
                            rsp_frame_length, rsp_route_path, rsp_frame_class);
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   // watchdog: any handshake on any channel restarts the count
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // sender tasks
   // --------------------------------------------------------------------------

   // present one byte, optionally after random idle cycles, and hold it
   // until the block takes it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
   endtask

   // stop sending and wait until every expected item has come back,
   // then let bytes that cause no result clear the pipe
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // max_payload write, only ever called after wait_drain
   task automatic write_max_payload(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.max_len = v;
   endtask

   function automatic logic [7:0] rand_no_sync();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == SYNC_BYTE) b = 8'h00;
      return b;
   endfunction

   // one well-formed frame: sync word, length, payload with random route
   // content and a random trailer; an oversize length stops after the header
   task automatic send_frame(input logic [15:0] len);
      logic [7:0] path_code;
      logic [7:0] type_code;
      logic [7:0] b;
      bit         pulse_shape;
      int         pick;
      pick = $urandom_range(9);
      case (pick)
         0:       path_code = CHR_0;
         1:       path_code = CHR_4;
         2:       path_code = CHR_6;
         3, 4, 5: path_code = CHR_3;
         6, 7, 8: path_code = CHR_5;
         default: path_code = 8'($urandom_range(255));
      endcase
      pick = $urandom_range(7);
      case (pick)
         0, 1:    type_code = CHR_0;
         2, 3, 4: type_code = CHR_1;
         5, 6:    type_code = CHR_2;
         default: type_code = 8'($urandom_range(255));
      endcase
      pulse_shape = 1'($urandom_range(1));
      repeat (4) send_byte(SYNC_BYTE);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      framed_items += 6;
      if (len <= sb.max_len) begin
         for (int i = 0; i < len; i++) begin
            if (i == 0) b = path_code;
            else if (i == 1) b = type_code;
            else if (i <= 4 && (pulse_shape || $urandom_range(2) == 0)) b = CHR_6;
            else b = 8'($urandom_range(255));
            send_byte(b);
         end
         // trailer content is ignored by the block, so anything goes
         repeat (4) send_byte(8'($urandom_range(255)));
         framed_items += len + 4;
      end
   endtask

   // junk between frames: random bytes, broken sync runs, or an extra sync
   // byte that turns into a bogus length; always leaves the parser hunting
   task automatic send_noise();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) begin
         repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
         send_byte(rand_no_sync());
      end else if (pick < 8 || sb.max_len >= 16'hEF00) begin
         // sync broken after one to three sync bytes
         repeat ($urandom_range(1, 3)) send_byte(SYNC_BYTE);
         send_byte(rand_no_sync());
      end else begin
         // five sync bytes: the fifth is read as length high, length is oversize
         repeat (5) send_byte(SYNC_BYTE);
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // frame length mix: mostly short, some boundaries, empties and oversize
   function automatic logic [15:0] pick_length();
      logic [15:0] len;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         len = 16'($urandom_range(16'hFFFF));
         if (len <= sb.max_len && len > 16'd64) len = {10'd0, len[5:0]};
      end else if (pick < 20) begin
         if (sb.max_len <= 16'd64)
            len = 16'(sb.max_len + $urandom_range(1));
         else
            len = 16'($urandom_range(3));
      end else if (pick < 28) begin
         len = 16'h0000;
      end else begin
         len = 16'($urandom_range(1, 12));
      end
      return len;
   endfunction

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      int          phase_start;
      logic [15:0] max_setting[6];
      int          send_pct[6];
      int          recv_pct[6];
      logic [7:0]  directed[$];

      // settings per phase: reset value, zero, full range, tiny, random, eight
      max_setting = '{MAX_PAYLOAD_RST, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd8};
      max_setting[3] = 16'($urandom_range(1, 40));
      max_setting[4] = 16'($urandom_range(16'hFFFF));
      send_pct = '{13, 13, 79, 79, 0, 0};
      recv_pct = '{79, 79, 13, 13, 0, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sync broken, extra sync byte read as length (oversize drop),
      // oversize header, empty frame, one-byte upper frame, upper pulse
      directed = '{8'hEF, 8'hEF, 8'hEF, 8'h12,
                   8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'h00,
                   8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'h04, 8'h00,
                   8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'h00, 8'h00,
                   8'hFF, 8'h00, 8'hEF, 8'h55,
                   8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'h00, 8'h01, CHR_3,
                   8'h00, 8'hFF, 8'h00, 8'hFF,
                   8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'h00, 8'h05,
                   CHR_3, CHR_1, CHR_6, CHR_6, CHR_6,
                   8'h01, 8'h02, 8'h03, 8'h04};
      foreach (directed[i]) send_byte(directed[i]);
      wait_drain();

      for (int p = 0; p < 6; p++) begin
         // block is idle here: safe to change the register and the pacing
         send_gap_pct = send_pct[p];
         recv_gap_pct = recv_pct[p];
         if (p > 0) write_max_payload(max_setting[p]);

         // a header one past the reset limit is dropped at once
         if (p == 0) send_frame(MAX_PAYLOAD_RST + 16'd1);

         phase_start = framed_items;
         while (framed_items < phase_start + PHASE_ITEMS) begin
            if ($urandom_range(3) == 0) send_noise();
            send_frame(pick_length());
            // sender holds off near the middle of each phase until all results are back
            if (framed_items >= phase_start + PHASE_ITEMS / 2 &&
                framed_items - phase_start < PHASE_ITEMS / 2 + 24)
               wait_drain();
         end
         wait_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
